// ===== rtl/core/bgd_pkg.sv =====
package bgd_pkg;

	// Width of the timestamps and of every time difference.
	localparam int TIME_BITS = 32;
	// Width of the press counter, which saturates at its all-ones value.
	localparam int TALLY_BITS = 8;

	// Widths of the fields that the channels carry.
	localparam int NOW_BITS = 32;
	localparam int CFG_BITS = 16;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;

	typedef logic [TIME_BITS-1:0] stamp_t;
	typedef logic [TALLY_BITS-1:0] tally_t;
	typedef logic [CFG_BITS-1:0] cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_PRESSED  = 2'd1,
		ST_HELD     = 2'd2,
		ST_RELEASED = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		G_NONE   = 2'd0,
		G_SINGLE = 2'd1,
		G_DOUBLE = 2'd2,
		G_LONG   = 2'd3
	} gesture_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_DEBOUNCE      = 2'd0,
		REG_LONG_PRESS    = 2'd1,
		REG_DOUBLE_WINDOW = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	localparam cfg_t DEBOUNCE_RESET      = 16'd50;
	localparam cfg_t LONG_PRESS_RESET    = 16'd1000;
	localparam cfg_t DOUBLE_WINDOW_RESET = 16'd300;

endpackage

// ===== rtl/core/bgd_in_if.sv =====
interface bgd_in_if;
	logic valid;
	logic ready;
	logic [bgd_pkg::NOW_BITS-1:0] now_ms;
	logic button_down;
	logic take_gesture;

	modport source (output valid, output now_ms, output button_down, output take_gesture,
		input ready);
	modport sink (input valid, input now_ms, input button_down, input take_gesture,
		output ready);
endinterface

// ===== rtl/core/bgd_out_if.sv =====
interface bgd_out_if;
	logic valid;
	logic ready;
	logic [1:0] fsm_state;
	logic is_down;
	logic [1:0] gesture_out;

	modport source (output valid, output fsm_state, output is_down, output gesture_out,
		input ready);
	modport sink (input valid, input fsm_state, input is_down, input gesture_out,
		output ready);
endinterface

// ===== rtl/core/button_gesture_detector.sv =====
// A poll accepted into the input register moves on into the result register when the result register
// is free or is being emptied in that cycle.
// Throughput: one poll per cycle; the input register and the result register each
// take a new transfer while the other side is stalled, so only a stalled output stops input.
// Reset (arst_n low, asynchronous): machine idle, stamps, tally and latch zero,
// configuration registers at 50, 1000 and 300 ms, both pipeline registers empty.
module button_gesture_detector (
	input  logic clk,
	input  logic arst_n,
	bgd_in_if.sink poll_in,
	bgd_out_if.source result_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bgd_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [bgd_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [bgd_pkg::APB_DATA_BITS-1:0] prdata,
	output logic pready
);

	// Configuration registers.
	bgd_pkg::cfg_t debounce_q;
	bgd_pkg::cfg_t long_press_q;
	bgd_pkg::cfg_t double_window_q;
	bgd_pkg::reg_index_t reg_index;

	// Input register.
	logic valid_s1;
	logic [bgd_pkg::NOW_BITS-1:0] now_s1;
	logic down_s1;
	logic take_s1;

	// Machine state.
	bgd_pkg::state_t state_q;
	bgd_pkg::stamp_t debounce_stamp_q;
	bgd_pkg::stamp_t press_start_q;
	bgd_pkg::stamp_t release_stamp_q;
	bgd_pkg::tally_t tally_q;
	bgd_pkg::gesture_t latch_q;

	// Result register.
	logic out_valid_q;
	bgd_pkg::state_t out_state_q;
	logic out_down_q;
	bgd_pkg::gesture_t out_gesture_q;

	// Next-state logic.
	logic advance;
	bgd_pkg::stamp_t now_t;
	bgd_pkg::stamp_t since_edge;
	bgd_pkg::stamp_t since_press;
	bgd_pkg::stamp_t since_release;
	logic edge_ok;
	logic long_ok;
	logic window_done;
	bgd_pkg::state_t state_d;
	bgd_pkg::stamp_t debounce_stamp_d;
	bgd_pkg::stamp_t press_start_d;
	bgd_pkg::stamp_t release_stamp_d;
	bgd_pkg::tally_t tally_d;
	bgd_pkg::gesture_t latch_mid;
	bgd_pkg::gesture_t latch_d;
	bgd_pkg::gesture_t gesture_d;

	// The configuration port is always ready; the register index is the word address.
	assign pready = 1'b1;
	assign reg_index = bgd_pkg::reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bgd_pkg::DEBOUNCE_RESET;
			long_press_q <= bgd_pkg::LONG_PRESS_RESET;
			double_window_q <= bgd_pkg::DOUBLE_WINDOW_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_index)
				bgd_pkg::REG_DEBOUNCE: debounce_q <= pwdata[bgd_pkg::CFG_BITS-1:0];
				bgd_pkg::REG_LONG_PRESS: long_press_q <= pwdata[bgd_pkg::CFG_BITS-1:0];
				bgd_pkg::REG_DOUBLE_WINDOW: double_window_q <= pwdata[bgd_pkg::CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read-back of the configuration registers.
	always_comb begin
		unique case (reg_index)
			bgd_pkg::REG_DEBOUNCE: prdata = bgd_pkg::APB_DATA_BITS'(debounce_q);
			bgd_pkg::REG_LONG_PRESS: prdata = bgd_pkg::APB_DATA_BITS'(long_press_q);
			bgd_pkg::REG_DOUBLE_WINDOW: prdata = bgd_pkg::APB_DATA_BITS'(double_window_q);
			default: prdata = '0;
		endcase
	end

	// The poll in the input register moves on when the result register can take it.
	assign advance = valid_s1 && (!out_valid_q || result_out.ready);
	assign poll_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_in.ready) begin
			valid_s1 <= poll_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_in.ready && poll_in.valid) begin
			now_s1 <= poll_in.now_ms;
			down_s1 <= poll_in.button_down;
			take_s1 <= poll_in.take_gesture;
		end
	end

	// Time differences wrap modulo the timestamp width.
	assign now_t = bgd_pkg::TIME_BITS'(now_s1);
	assign since_edge = now_t - debounce_stamp_q;
	assign since_press = now_t - press_start_q;
	assign since_release = now_t - release_stamp_q;
	assign edge_ok = since_edge > bgd_pkg::TIME_BITS'(debounce_q);
	assign long_ok = since_press >= bgd_pkg::TIME_BITS'(long_press_q);
	assign window_done = since_release > bgd_pkg::TIME_BITS'(double_window_q);

	// Gesture state machine, advanced once per poll.
	always_comb begin
		state_d = state_q;
		debounce_stamp_d = debounce_stamp_q;
		press_start_d = press_start_q;
		release_stamp_d = release_stamp_q;
		tally_d = tally_q;
		latch_mid = latch_q;
		unique case (state_q)
			bgd_pkg::ST_IDLE: begin
				if (down_s1 && edge_ok) begin
					state_d = bgd_pkg::ST_PRESSED;
					press_start_d = now_t;
					debounce_stamp_d = now_t;
				end
			end
			bgd_pkg::ST_PRESSED: begin
				if (!down_s1 && edge_ok) begin
					state_d = bgd_pkg::ST_RELEASED;
					debounce_stamp_d = now_t;
					release_stamp_d = now_t;
					if (tally_q != '1) begin
						tally_d = tally_q + bgd_pkg::TALLY_BITS'(1);
					end
				end else if (down_s1 && long_ok) begin
					state_d = bgd_pkg::ST_HELD;
				end
			end
			bgd_pkg::ST_HELD: begin
				if (!down_s1 && edge_ok) begin
					state_d = bgd_pkg::ST_RELEASED;
					debounce_stamp_d = now_t;
				end
			end
			default: begin
				if (window_done) begin
					// One press latches single or long, two latch double, more latch nothing.
					if (tally_q == bgd_pkg::TALLY_BITS'(1)) begin
						latch_mid = long_ok ? bgd_pkg::G_LONG : bgd_pkg::G_SINGLE;
					end else if (tally_q == bgd_pkg::TALLY_BITS'(2)) begin
						latch_mid = bgd_pkg::G_DOUBLE;
					end
					tally_d = '0;
					state_d = bgd_pkg::ST_IDLE;
				end else if (down_s1 && edge_ok) begin
					state_d = bgd_pkg::ST_PRESSED;
					press_start_d = now_t;
					debounce_stamp_d = now_t;
				end
			end
		endcase

		// A hold latches long when nothing is pending; taking the gesture clears the latch.
		if (state_d == bgd_pkg::ST_HELD && latch_mid == bgd_pkg::G_NONE) begin
			latch_mid = bgd_pkg::G_LONG;
		end
		gesture_d = take_s1 ? latch_mid : bgd_pkg::G_NONE;
		latch_d = take_s1 ? bgd_pkg::G_NONE : latch_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgd_pkg::ST_IDLE;
			debounce_stamp_q <= '0;
			press_start_q <= '0;
			release_stamp_q <= '0;
			tally_q <= '0;
			latch_q <= bgd_pkg::G_NONE;
		end else if (advance) begin
			state_q <= state_d;
			debounce_stamp_q <= debounce_stamp_d;
			press_start_q <= press_start_d;
			release_stamp_q <= release_stamp_d;
			tally_q <= tally_d;
			latch_q <= latch_d;
		end
	end

	// Result register and its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= state_d;
			out_down_q <= (state_d == bgd_pkg::ST_PRESSED) || (state_d == bgd_pkg::ST_HELD);
			out_gesture_q <= gesture_d;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.fsm_state = out_state_q;
	assign result_out.is_down = out_down_q;
	assign result_out.gesture_out = out_gesture_q;

	// A poll that does not ask for the gesture reports none.
	a_no_take_no_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !take_s1 |=> result_out.gesture_out == bgd_pkg::G_NONE)
		else $error("gesture reported without a take request");

	// Input stalls only behind a full input register and a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!poll_in.ready |-> valid_s1 && out_valid_q && !result_out.ready)
		else $error("input stalled without a stalled result");

	// A taken gesture leaves the latch empty.
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && take_s1 |=> latch_q == bgd_pkg::G_NONE)
		else $error("latch not cleared by a take");

endmodule

// ===== tb/tb_button_gesture_detector.sv =====
`timescale 1ns / 1ps

module tb_button_gesture_detector;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_CYCLES = 80;

	typedef struct packed {
		bgd_pkg::state_t st;
		logic down;
		bgd_pkg::gesture_t g;
	} poll_result_t;

	typedef struct packed {
		bgd_pkg::stamp_t now;
		logic down;
		logic take;
		logic fixed;
		poll_result_t want;
	} script_row_t;

	localparam poll_result_t FROM_PREDICTOR = '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_NONE};

	// Directed polls: each gesture kind, bounce rejection, a long hold, three presses
	// and a time wrap with a backward jump. Rows with the fixed flag carry their result.
	script_row_t script [0:25] = '{
		'{32'd10, 1'b1, 1'b0, 1'b1, '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_NONE}},
		'{32'd51, 1'b1, 1'b1, 1'b0, FROM_PREDICTOR},
		'{32'd80, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd200, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd300, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd400, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd701, 1'b0, 1'b1, 1'b1, '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_DOUBLE}},
		'{32'd800, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd900, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd1201, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd1202, 1'b0, 1'b1, 1'b1, '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_SINGLE}},
		'{32'd1203, 1'b0, 1'b1, 1'b0, FROM_PREDICTOR},
		'{32'd2000, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd3000, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd3500, 1'b0, 1'b1, 1'b1, '{bgd_pkg::ST_RELEASED, 1'b0, bgd_pkg::G_LONG}},
		'{32'd3801, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4000, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4100, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4200, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4300, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4400, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4500, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd4801, 1'b0, 1'b1, 1'b1, '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_NONE}},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'h0000_0033, 1'b0, 1'b0, 1'b0, FROM_PREDICTOR},
		'{32'd0, 1'b0, 1'b1, 1'b1, '{bgd_pkg::ST_IDLE, 1'b0, bgd_pkg::G_SINGLE}}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bgd_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [bgd_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [bgd_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;

	bgd_in_if poll_if ();
	bgd_out_if res_if ();

	button_gesture_detector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.poll_in(poll_if),
		.result_out(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Timing registers and machine state as the predictor sees them.
	bgd_pkg::cfg_t debounce_cfg = bgd_pkg::DEBOUNCE_RESET;
	bgd_pkg::cfg_t long_cfg = bgd_pkg::LONG_PRESS_RESET;
	bgd_pkg::cfg_t window_cfg = bgd_pkg::DOUBLE_WINDOW_RESET;
	bgd_pkg::state_t fsm_model = bgd_pkg::ST_IDLE;
	bgd_pkg::stamp_t deb_stamp = '0;
	bgd_pkg::stamp_t press_stamp = '0;
	bgd_pkg::stamp_t rel_stamp = '0;
	bgd_pkg::tally_t press_count = '0;
	bgd_pkg::gesture_t latch_model = bgd_pkg::G_NONE;

	poll_result_t pending_results[$];
	bgd_pkg::stamp_t poll_clock = '0;
	int polls_sent = 0;
	int error_count = 0;
	int cycle_count = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	bit holdoff_pending = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the gesture machine by one poll and return the result it reports.
	function automatic poll_result_t advance_gesture_fsm(bgd_pkg::stamp_t now, logic down,
			logic take);
		poll_result_t r;
		logic edge_ok;
		edge_ok = bgd_pkg::stamp_t'(now - deb_stamp) > bgd_pkg::stamp_t'(debounce_cfg);
		case (fsm_model)
			bgd_pkg::ST_IDLE: begin
				if (down && edge_ok) begin
					fsm_model = bgd_pkg::ST_PRESSED;
					press_stamp = now;
					deb_stamp = now;
				end
			end
			bgd_pkg::ST_PRESSED: begin
				if (!down && edge_ok) begin
					fsm_model = bgd_pkg::ST_RELEASED;
					deb_stamp = now;
					rel_stamp = now;
					// The press count saturates instead of wrapping.
					if (press_count != '1)
						press_count = press_count + 1'b1;
				end else if (down && bgd_pkg::stamp_t'(now - press_stamp)
						>= bgd_pkg::stamp_t'(long_cfg)) begin
					fsm_model = bgd_pkg::ST_HELD;
				end
			end
			bgd_pkg::ST_HELD: begin
				// A release after a long hold is not counted as a press.
				if (!down && edge_ok) begin
					fsm_model = bgd_pkg::ST_RELEASED;
					deb_stamp = now;
				end
			end
			default: begin
				if (bgd_pkg::stamp_t'(now - rel_stamp) > bgd_pkg::stamp_t'(window_cfg)) begin
					// Window closed: one press is single or long, two are double,
					// anything else latches nothing.
					if (press_count == bgd_pkg::tally_t'(1)) begin
						if (bgd_pkg::stamp_t'(now - press_stamp) >= bgd_pkg::stamp_t'(long_cfg))
							latch_model = bgd_pkg::G_LONG;
						else
							latch_model = bgd_pkg::G_SINGLE;
					end else if (press_count == bgd_pkg::tally_t'(2)) begin
						latch_model = bgd_pkg::G_DOUBLE;
					end
					press_count = '0;
					fsm_model = bgd_pkg::ST_IDLE;
				end else if (down && edge_ok) begin
					fsm_model = bgd_pkg::ST_PRESSED;
					press_stamp = now;
					deb_stamp = now;
				end
			end
		endcase
		if (fsm_model == bgd_pkg::ST_HELD && latch_model == bgd_pkg::G_NONE)
			latch_model = bgd_pkg::G_LONG;
		r.st = fsm_model;
		r.down = (fsm_model == bgd_pkg::ST_PRESSED || fsm_model == bgd_pkg::ST_HELD);
		if (take) begin
			r.g = latch_model;
			latch_model = bgd_pkg::G_NONE;
		end else begin
			r.g = bgd_pkg::G_NONE;
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Offer one poll, wait for its transfer and record what it should produce.
	// Entered and left at a falling edge.
	task automatic offer_poll(input bgd_pkg::stamp_t now, input logic down, input logic take,
			input logic fixed, input poll_result_t want);
		poll_result_t predicted;
		while (src_idle_on && $urandom_range(0, 99) < 35) begin
			poll_if.valid <= 1'b0;
			@(negedge clk);
		end
		poll_if.valid <= 1'b1;
		poll_if.now_ms <= now;
		poll_if.button_down <= down;
		poll_if.take_gesture <= take;
		@(posedge clk);
		while (!poll_if.ready)
			@(posedge clk);
		predicted = advance_gesture_fsm(now, down, take);
		pending_results.push_back(fixed ? want : predicted);
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic send_level(input bgd_pkg::stamp_t now, input logic down);
		offer_poll(now, down, $urandom_range(0, 99) < 30, 1'b0, FROM_PREDICTOR);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One configuration transfer: setup cycle, then access cycle.
	task automatic apb_access(input bgd_pkg::reg_index_t idx, input logic wr,
			input bgd_pkg::cfg_t wdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'b0, wdata};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr) begin
			case (idx)
				bgd_pkg::REG_DEBOUNCE: debounce_cfg = wdata;
				bgd_pkg::REG_LONG_PRESS: long_cfg = wdata;
				bgd_pkg::REG_DOUBLE_WINDOW: window_cfg = wdata;
				default: ;
			endcase
		end else begin
			case (idx)
				bgd_pkg::REG_DEBOUNCE: if (prdata !== {16'b0, debounce_cfg})
					note_mismatch("debounce_ms readback", debounce_cfg, prdata);
				bgd_pkg::REG_LONG_PRESS: if (prdata !== {16'b0, long_cfg})
					note_mismatch("long_press_ms readback", long_cfg, prdata);
				bgd_pkg::REG_DOUBLE_WINDOW: if (prdata !== {16'b0, window_cfg})
					note_mismatch("double_window_ms readback", window_cfg, prdata);
				default: ;
			endcase
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Program the three timing registers, poke the unused index, then read back.
	task automatic set_timing(input bgd_pkg::cfg_t deb, input bgd_pkg::cfg_t lng,
			input bgd_pkg::cfg_t win);
		apb_access(bgd_pkg::REG_DEBOUNCE, 1'b1, deb);
		apb_access(bgd_pkg::REG_LONG_PRESS, 1'b1, lng);
		apb_access(bgd_pkg::REG_DOUBLE_WINDOW, 1'b1, win);
		apb_access(bgd_pkg::REG_UNUSED, 1'b1, bgd_pkg::cfg_t'($urandom));
		apb_access(bgd_pkg::REG_DEBOUNCE, 1'b0, '0);
		apb_access(bgd_pkg::REG_LONG_PRESS, 1'b0, '0);
		apb_access(bgd_pkg::REG_DOUBLE_WINDOW, 1'b0, '0);
	endtask

	// A time step that lands on, next to, or well around a threshold.
	function automatic bgd_pkg::stamp_t near_span(bgd_pkg::cfg_t span);
		bgd_pkg::stamp_t v;
		v = bgd_pkg::stamp_t'(span);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return v;
			2: return v + 1;
			3: return (v == 0) ? v : v - 1;
			4: return v / 2;
			5: return bgd_pkg::stamp_t'($urandom_range(0, v));
			6: return v + bgd_pkg::stamp_t'($urandom_range(1, v + 1));
			default: return bgd_pkg::stamp_t'($urandom_range(1, 4));
		endcase
	endfunction

	// A press sequence with random timing: bounces, holds near the long threshold
	// and gaps near the double-press window.
	task automatic play_gesture();
		int presses;
		int holds;
		presses = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
		for (int p = 0; p < presses; p++) begin
			poll_clock += near_span(debounce_cfg);
			send_level(poll_clock, 1'b1);
			if ($urandom_range(0, 3) == 0) begin
				poll_clock += bgd_pkg::stamp_t'($urandom_range(0, debounce_cfg));
				send_level(poll_clock, 1'b0);
				poll_clock += bgd_pkg::stamp_t'($urandom_range(0, 3));
				send_level(poll_clock, 1'b1);
			end
			holds = $urandom_range(0, 3);
			for (int h = 0; h < holds; h++) begin
				poll_clock += ($urandom_range(0, 2) == 0) ? near_span(long_cfg)
					: near_span(debounce_cfg);
				send_level(poll_clock, 1'b1);
			end
			poll_clock += near_span(debounce_cfg);
			send_level(poll_clock, 1'b0);
			if ($urandom_range(0, 1) == 0) begin
				poll_clock += near_span(window_cfg / 2);
				send_level(poll_clock, 1'b0);
			end
		end
		holds = $urandom_range(1, 3);
		for (int t = 0; t < holds; t++) begin
			poll_clock += near_span(window_cfg);
			send_level(poll_clock, 1'b0);
		end
	endtask

	// Polls with no structure: time jumps anywhere, backward, or barely moves.
	task automatic inject_noise();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 2))
				0: poll_clock = bgd_pkg::stamp_t'($urandom);
				1: poll_clock = poll_clock - bgd_pkg::stamp_t'($urandom_range(0, 100));
				default: poll_clock = poll_clock + bgd_pkg::stamp_t'($urandom_range(0, 3));
			endcase
			send_level(poll_clock, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input int n_items, input bit src_idle, input bit sink_idle,
			input bit squeeze);
		int goal;
		bit paused;
		goal = polls_sent + n_items;
		paused = 1'b0;
		src_idle_on = src_idle;
		sink_idle_on = sink_idle;
		if (squeeze)
			holdoff_pending = 1'b1;
		while (polls_sent < goal) begin
			// Halfway through, stop sending until every result is back.
			if (squeeze && !paused && polls_sent >= goal - n_items / 2) begin
				poll_if.valid <= 1'b0;
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 99) < 15)
				inject_noise();
			else
				play_gesture();
		end
		poll_if.valid <= 1'b0;
		drain_results();
	endtask

	// Result side readiness: random stalls, or one long hold-off on request.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_pending) begin
				res_if.ready <= 1'b0;
				for (int k = 0; k < HOLDOFF_CYCLES; k++)
					@(negedge clk);
				holdoff_pending = 1'b0;
			end
			res_if.ready <= !(sink_idle_on && $urandom_range(0, 99) < 35);
		end
	end

	// Compare every result transfer with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		poll_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, fsm_state", -1, res_if.fsm_state);
			end else begin
				want = pending_results.pop_front();
				if (res_if.fsm_state !== want.st)
					note_mismatch("fsm_state", want.st, res_if.fsm_state);
				if (res_if.is_down !== want.down)
					note_mismatch("is_down", want.down, res_if.is_down);
				if (res_if.gesture_out !== want.g)
					note_mismatch("gesture_out", want.g, res_if.gesture_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_gesture_detector verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		poll_if.valid = 1'b0;
		poll_if.now_ms = '0;
		poll_if.button_down = 1'b0;
		poll_if.take_gesture = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the timing registers.
		apb_access(bgd_pkg::REG_DEBOUNCE, 1'b0, '0);
		apb_access(bgd_pkg::REG_LONG_PRESS, 1'b0, '0);
		apb_access(bgd_pkg::REG_DOUBLE_WINDOW, 1'b0, '0);

		for (int i = 0; i < 26; i++)
			offer_poll(script[i].now, script[i].down, script[i].take, script[i].fixed,
				script[i].want);
		poll_if.valid <= 1'b0;
		drain_results();

		// Press count saturation: 257 presses inside one wide window must latch
		// nothing, where a wrapping counter would end at one press.
		set_timing(16'd0, 16'hFFFF, 16'hFFFF);
		poll_clock += 32'd70000;
		send_level(poll_clock, 1'b0);
		poll_clock += 32'd70000;
		send_level(poll_clock, 1'b0);
		for (int i = 0; i < 257; i++) begin
			poll_clock += 1;
			send_level(poll_clock, 1'b1);
			poll_clock += 1;
			send_level(poll_clock, 1'b0);
		end
		poll_clock += 32'd70000;
		send_level(poll_clock, 1'b0);
		offer_poll(poll_clock + 1, 1'b0, 1'b1, 1'b0, FROM_PREDICTOR);
		poll_if.valid <= 1'b0;
		drain_results();

		// Random gestures under several timing settings.
		set_timing(bgd_pkg::DEBOUNCE_RESET, bgd_pkg::LONG_PRESS_RESET,
			bgd_pkg::DOUBLE_WINDOW_RESET);
		run_phase(240, 1'b1, 1'b1, 1'b0);
		set_timing(16'd0, 16'd0, 16'd0);
		run_phase(240, 1'b1, 1'b1, 1'b0);
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(240, 1'b1, 1'b1, 1'b0);
		set_timing(bgd_pkg::cfg_t'($urandom_range(0, 200)),
			bgd_pkg::cfg_t'($urandom_range(0, 200)),
			bgd_pkg::cfg_t'($urandom_range(0, 200)));
		run_phase(240, 1'b0, 1'b0, 1'b0);
		set_timing(bgd_pkg::cfg_t'($urandom), bgd_pkg::cfg_t'($urandom),
			bgd_pkg::cfg_t'($urandom));
		run_phase(240, 1'b1, 1'b1, 1'b1);

		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("button_gesture_detector verification clean");
		else
			$display("button_gesture_detector verification failed");
		$finish;
	end

endmodule
